// ===== hdl/swmad_pkg.sv =====
// swmad_pkg: shared types and constants for the sliding window median cost unit
// no dependencies
package swmad_pkg;
  localparam int unsigned CFG_BITS = 9;
  localparam int unsigned COST_BITS = 38;

  typedef struct packed {
    logic start;
    logic clear;
    logic sum_step;
    logic finish;
  } swmad_cmd_t;

  typedef struct packed {
    logic sum_done;
    logic full;
  } swmad_sts_t;
endpackage

// ===== hdl/swmad_stream_if.sv =====
// swmad_stream_if: valid/ready channel carrying a payload of parameterized width
// no dependencies
interface swmad_stream_if #(
  parameter int unsigned W = 8
);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/swmad_datapath.sv =====
// swmad_datapath: arrival ring, sorted cell chain and cost accumulator
// depends on swmad_pkg
module swmad_datapath #(
  parameter int unsigned MAX_WINDOW  = 256,
  parameter int unsigned SAMPLE_BITS = 30
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  swmad_pkg::swmad_cmd_t         cmd,
  output swmad_pkg::swmad_sts_t         sts,
  input  logic [SAMPLE_BITS-1:0]        sample,
  input  logic [swmad_pkg::CFG_BITS-1:0] win,
  output logic [swmad_pkg::COST_BITS-1:0] cost
);
  import swmad_pkg::*;

  localparam int unsigned AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int unsigned CW = $clog2(MAX_WINDOW + 1);

  logic [SAMPLE_BITS-1:0] ring_r [MAX_WINDOW];
  logic [SAMPLE_BITS-1:0] cell_r [MAX_WINDOW];
  logic [SAMPLE_BITS-1:0] cell_nxt [MAX_WINDOW];
  logic [SAMPLE_BITS-1:0] bv [MAX_WINDOW];
  logic [SAMPLE_BITS-1:0] old_r;
  logic [SAMPLE_BITS-1:0] med_r;
  logic [CW-1:0]          wp_r, fill_r, idx_r, mi;
  logic [COST_BITS-1:0]   acc_r;
  logic                   drop;
  logic [MAX_WINDOW:0]    gtx;
  logic [MAX_WINDOW-1:0]  eq, rm, sh, bgt;
  logic [MAX_WINDOW-1:0]  ge_rm;

  assign mi = CW'((win - 1'b1) >> 1);
  assign drop = (fill_r >= CW'(win));
  assign sts.full = (fill_r + CW'(!drop)) >= CW'(win);
  assign sts.sum_done = (idx_r >= CW'(win));
  assign cost = acc_r;

  // removal point: first cell equal to the oldest sample
  always_comb begin
    gtx[MAX_WINDOW] = 1'b1;
    for (int i = 0; i < MAX_WINDOW; i++) begin
      eq[i] = (CW'(i) < fill_r) && (cell_r[i] == old_r) && drop;
      gtx[i] = (CW'(i) >= fill_r) || (cell_r[i] > sample);
    end
    ge_rm[0] = 1'b0;
    rm[0] = eq[0];
    for (int i = 1; i < MAX_WINDOW; i++) begin
      ge_rm[i] = ge_rm[i-1] | eq[i-1];
      rm[i] = eq[i] & ~ge_rm[i];
    end
  end

  // one pass: close the gap of the oldest sample, then open one for the new sample
  always_comb begin
    for (int i = 0; i < MAX_WINDOW; i++) begin
      sh[i] = ge_rm[i] | rm[i];
      if (sh[i] && i < MAX_WINDOW-1) bv[i] = cell_r[(i < MAX_WINDOW-1) ? i+1 : i];
      else bv[i] = cell_r[i];
      bgt[i] = sh[i] ? gtx[i+1] : gtx[i];
    end
    for (int i = 0; i < MAX_WINDOW; i++) begin
      if (!bgt[i]) cell_nxt[i] = bv[i];
      else if (i == 0 || !bgt[(i > 0) ? i-1 : 0]) cell_nxt[i] = sample;
      else cell_nxt[i] = bv[(i > 0) ? i-1 : 0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear) begin
      wp_r   <= '0;
      fill_r <= '0;
    end else if (cmd.start) begin
      ring_r[wp_r[AW-1:0]] <= sample;
      wp_r <= (wp_r + 1'b1 >= CW'(win)) ? '0 : wp_r + 1'b1;
      if (!drop) fill_r <= fill_r + 1'b1;
      for (int i = 0; i < MAX_WINDOW; i++) cell_r[i] <= cell_nxt[i];
    end
  end

  always_ff @(posedge clk) begin
    old_r <= ring_r[wp_r[AW-1:0]];
    if (cmd.finish) begin
      idx_r <= '0;
      acc_r <= '0;
      med_r <= cell_r[mi[AW-1:0]];
    end else if (cmd.sum_step && !sts.sum_done) begin
      idx_r <= idx_r + 1'b1;
      if (cell_r[idx_r[AW-1:0]] >= med_r)
        acc_r <= acc_r + COST_BITS'(cell_r[idx_r[AW-1:0]] - med_r);
      else
        acc_r <= acc_r + COST_BITS'(med_r - cell_r[idx_r[AW-1:0]]);
    end
  end
endmodule

// ===== hdl/swmad_ctrl.sv =====
// swmad_ctrl: sequencer for insert, cost accumulation and result hand-off
// depends on swmad_pkg
module swmad_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic                  in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  output swmad_pkg::swmad_cmd_t cmd,
  input  swmad_pkg::swmad_sts_t sts
);
  import swmad_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MED  = 2'd1;
  localparam logic [1:0] S_SUM  = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  logic [1:0] st_r, st_nxt;
  logic       fire;

  assign in_ready = (st_r == S_IDLE);
  assign out_valid = (st_r == S_OUT);
  assign fire = in_valid && in_ready;

  always_comb begin
    cmd.start = fire;
    cmd.clear = cfg_we;
    cmd.finish = (st_r == S_MED);
    cmd.sum_step = (st_r == S_SUM);
    st_nxt = st_r;
    case (st_r)
      S_IDLE: if (fire && sts.full) st_nxt = S_MED;
      S_MED: st_nxt = S_SUM;
      S_SUM: if (sts.sum_done) st_nxt = S_OUT;
      S_OUT: if (out_ready) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= S_IDLE;
    else st_r <= st_nxt;
  end
endmodule

// ===== hdl/sliding_window_median_abs_deviation_unit.sv =====
// sliding_window_median_abs_deviation_unit: top level, sorted window with median cost
// depends on swmad_pkg, swmad_stream_if, swmad_ctrl, swmad_datapath
// a sample is inserted into the sorted chain when it is accepted; when the window is full
// the median is latched, then the cost is summed one cell per cycle through the accumulator
// throughput is one request per cycle while filling; once full, no request is taken until the cost is accepted
// synchronous reset empties the window and sets window_size to 1; config write empties it
module sliding_window_median_abs_deviation_unit #(
  parameter int unsigned MAX_WINDOW  = 256,
  parameter int unsigned SAMPLE_BITS = 30
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [swmad_pkg::CFG_BITS-1:0] cfg_wdata,
  swmad_stream_if.sink                 in_sample,
  swmad_stream_if.source               out_cost
);
  import swmad_pkg::*;

  logic [CFG_BITS-1:0] win_r;
  swmad_cmd_t          cmd;
  swmad_sts_t          sts;

  always_ff @(posedge clk) begin
    if (!rst_n) win_r <= CFG_BITS'(1);
    else if (cfg_we) begin
      if (cfg_wdata == '0) win_r <= CFG_BITS'(1);
      else if (32'(cfg_wdata) > MAX_WINDOW) win_r <= CFG_BITS'(MAX_WINDOW);
      else win_r <= cfg_wdata;
    end
  end

  swmad_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we),
    .in_valid(in_sample.valid), .in_ready(in_sample.ready),
    .out_valid(out_cost.valid), .out_ready(out_cost.ready),
    .cmd(cmd), .sts(sts)
  );

  swmad_datapath #(.MAX_WINDOW(MAX_WINDOW), .SAMPLE_BITS(SAMPLE_BITS)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .sample(in_sample.data[SAMPLE_BITS-1:0]), .win(win_r), .cost(out_cost.data)
  );
endmodule

// ===== hdl/swmad_checker.sv =====
// swmad_checker: port-level assertions for the median cost unit
// depends on sliding_window_median_abs_deviation_unit ports
module swmad_checker (
  input logic clk,
  input logic rst_n,
  input logic cfg_we,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready
);
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("accept while result pending");
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid) else $error("result after reset");
  a_cfg_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |-> !out_valid) else $error("config write while result pending");
endmodule

bind sliding_window_median_abs_deviation_unit swmad_checker u_chk (
  .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we),
  .in_valid(in_sample.valid), .in_ready(in_sample.ready),
  .out_valid(out_cost.valid), .out_ready(out_cost.ready)
);

// ===== dv/sliding_window_median_abs_deviation_unit_tb.sv =====
// sliding_window_median_abs_deviation_unit_tb: checks the median cost unit against a
// behavioral window model with random stalls on both channels
// depends on swmad_pkg, swmad_stream_if, sliding_window_median_abs_deviation_unit
`timescale 1ns / 1ps

class swmad_cost_board;
  int unsigned win_len;
  bit [29:0] ring[256];
  int unsigned wr_ptr;
  int unsigned fill;
  bit [29:0] sorted_q[$];
  bit [37:0] cost_q[$];
  int unsigned errors;

  function new();
    win_len = 1;
    clear();
    errors = 0;
  endfunction

  function void clear();
    wr_ptr = 0;
    fill = 0;
    sorted_q.delete();
  endfunction

  function void set_window(bit [8:0] v);
    int unsigned w;
    w = v;
    if (w == 0) w = 1;
    if (w > 256) w = 256;
    win_len = w;
    clear();
  endfunction

  function void note_sample(bit [29:0] s);
    int unsigned pos, mi;
    bit [29:0] med;
    bit [37:0] acc;
    if (wr_ptr >= win_len) wr_ptr = 0;
    if (fill >= win_len) begin
      foreach (sorted_q[i]) begin
        if (sorted_q[i] == ring[wr_ptr]) begin
          sorted_q.delete(i);
          break;
        end
      end
      fill--;
    end
    ring[wr_ptr] = s;
    pos = sorted_q.size();
    while (pos > 0 && sorted_q[pos-1] > s) pos--;
    sorted_q.insert(pos, s);
    fill++;
    wr_ptr++;
    if (wr_ptr >= win_len) wr_ptr = 0;
    if (fill < win_len) return;
    mi = (win_len - 1) / 2;
    med = sorted_q[mi];
    acc = 0;
    foreach (sorted_q[i]) acc += (sorted_q[i] > med) ? sorted_q[i] - med : med - sorted_q[i];
    cost_q.push_back(acc);
  endfunction

  function void check_cost(bit [37:0] got);
    bit [37:0] want;
    if (cost_q.size() == 0) begin
      errors++;
      if (errors <= 10) $display("unexpected cost %0d", got);
      return;
    end
    want = cost_q.pop_front();
    if (want !== got) begin
      errors++;
      if (errors <= 10) $display("cost mismatch: expected %0d actual %0d", want, got);
    end
  endfunction
endclass

module sliding_window_median_abs_deviation_unit_tb;
  localparam int unsigned WDOG_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [swmad_pkg::CFG_BITS-1:0] cfg_wdata = '0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned idle_cycles = 0;
  logic out_ready_r = 1'b0;

  swmad_stream_if #(.W(30)) in_sample ();
  swmad_stream_if #(.W(swmad_pkg::COST_BITS)) out_cost ();

  swmad_cost_board board = new();

  sliding_window_median_abs_deviation_unit i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_sample(in_sample.sink),
    .out_cost (out_cost.source)
  );

  always #4 clk = ~clk;

  initial begin
    in_sample.valid = 1'b0;
    in_sample.data = '0;
  end
  assign out_cost.ready = out_ready_r;

  always @(posedge clk) begin
    out_ready_r <= ($urandom_range(99) >= recv_stall_pct);
    if (rst_n && out_cost.valid && out_cost.ready) board.check_cost(out_cost.data);
    if (rst_n && in_sample.valid && in_sample.ready) board.note_sample(in_sample.data);
    if ((in_sample.valid && in_sample.ready) || (out_cost.valid && out_cost.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WDOG_LIMIT) begin
      $display("sliding_window_median_abs_deviation_unit_tb: FAIL");
      $finish;
    end
  end

  task automatic send_sample(input logic [29:0] s);
    while ($urandom_range(99) < send_idle_pct) begin
      in_sample.valid <= 1'b0;
      @(posedge clk);
    end
    in_sample.valid <= 1'b1;
    in_sample.data <= s;
    do @(posedge clk); while (!in_sample.ready);
  endtask

  task automatic drain();
    in_sample.valid <= 1'b0;
    while (board.cost_q.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic write_window(input logic [8:0] v);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    board.set_window(v);
  endtask

  function automatic logic [29:0] rand_sample(input int unsigned mode);
    case (mode)
      0: return 30'($urandom_range(7));
      1: return 30'h3fffffff - 30'($urandom_range(3));
      default: return 30'($urandom());
    endcase
  endfunction

  task automatic run_phase(input logic [8:0] win, input int unsigned n);
    int unsigned mode;
    write_window(win);
    mode = $urandom_range(2);
    for (int unsigned i = 0; i < n; i++) begin
      if ($urandom_range(19) == 0) mode = $urandom_range(2);
      send_sample(rand_sample(mode));
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // directed: extremes, default window of one, zero and oversize writes
    send_sample(30'h0);
    send_sample(30'h3fffffff);
    send_sample(30'h15555555);
    write_window(9'd0);
    send_sample(30'h2aaaaaaa);
    write_window(9'd4);
    send_sample(30'h3fffffff);
    send_sample(30'h0);
    send_sample(30'h3fffffff);
    send_sample(30'h0);
    send_sample(30'h3fffffff);
    send_sample(30'h5);
    send_sample(30'h5);
    write_window(9'd3);
    repeat (6) send_sample(30'h3fffffff);
    write_window(9'h1ff);
    for (int i = 0; i < 260; i++) send_sample(30'h3fffffff - i[29:0]);
    // random with idling phases
    for (int p = 0; p < 16; p++) begin
      case (p % 4)
        0: begin send_idle_pct = 0; recv_stall_pct = 0; end
        1: begin send_idle_pct = 66; recv_stall_pct = 0; end
        2: begin send_idle_pct = 0; recv_stall_pct = 66; end
        default: begin send_idle_pct = 16; recv_stall_pct = 16; end
      endcase
      case (p)
        3: run_phase(9'd256, 300);
        7: run_phase(9'd2, 100);
        11: run_phase(9'd1, 60);
        default: run_phase(9'($urandom_range(1, 16)), 110);
      endcase
    end
    drain();
    if (board.errors == 0)
      $display("sliding_window_median_abs_deviation_unit_tb: PASS");
    else
      $display("sliding_window_median_abs_deviation_unit_tb: FAIL");
    $finish;
  end
endmodule
